FILE: hw/rtl/deq_pkg.sv
// Shared widths, defaults and codes for the double-ended queue.
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int ACT_W     = 3;
    localparam int WORD_W    = 32;
    localparam int STAT_W    = 2;
    localparam int LEN_W     = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT  = 3'd0,
        ACT_INS_BACK   = 3'd1,
        ACT_REM_FRONT  = 3'd2,
        ACT_REM_BACK   = 3'd3,
        ACT_READ_AT    = 3'd4,
        ACT_PEEK_FRONT = 3'd5,
        ACT_PEEK_BACK  = 3'd6,
        ACT_CLEAR      = 3'd7
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/deq_if.sv
// Valid/ready channels for queue commands and queue results.
interface deq_in_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output action, output item_value, input ready);
    modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length_after;
    logic                     is_empty;

    modport source (output valid, output result_value, output status,
                    output length_after, output is_empty, input ready);
    modport sink   (input valid, input result_value, input status,
                    input length_after, input is_empty, output ready);
endinterface

FILE: hw/rtl/deq_store.sv
// Ring store: one write port and one registered read port.
module deq_store #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [deq_pkg::WORD_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [deq_pkg::WORD_W-1:0] o_rdata
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the read word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
// A command word accepted at an edge has its store read registered in the read stage;
// its result word is then registered in the output register for the result handshake.
// Throughput: one command word per cycle while the result side keeps taking words;
// each result passes the store's single registered read port and the output register.
// A stalled result holds in the output register; one more command may then sit in
// the read stage, after which the input stalls. Synchronous active-low reset empties
// the queue (front and count to zero); store contents are not cleared.
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Pointer state
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Read stage: the command whose store read is in flight
    logic          r_pend;
    logic          r_use_rd, n_use_rd;
    t_status       r_status, n_status;
    logic [CW-1:0] r_len;

    // Output register
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_value;
    t_status                  r_out_status;
    logic [CW-1:0]            r_out_len;

    // Store port controls
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] rdata;

    logic    accept, out_free, advance;
    logic    is_full, is_emp;
    logic    bad_pos;
    logic [AW-1:0] front_dec;
    t_action act;

    // Ring slot at an offset past the front; offset stays below DEPTH.
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] front,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_pend && out_free;
    assign i_in.ready = !r_pend || out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign act       = t_action'(i_in.action);
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_emp    = (r_count == '0);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    // Negative position, or one not below the count, is out of range.
    assign bad_pos   = i_in.item_value[WORD_W-1]
                    || (i_in.item_value[WORD_W-2:0] >= (WORD_W-1)'(r_count));

    // Decode the command: pointer update, store write and store read.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_use_rd = 1'b0;
        n_status = ST_OK;
        we       = 1'b0;
        waddr    = r_front;
        re       = 1'b0;
        raddr    = r_front;
        case (act)
            ACT_INS_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = accept;
                    waddr   = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_INS_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = accept;
                    waddr   = slot_at(r_front, r_count[AW-1:0]);
                    n_count = r_count + CW'(1);
                end
            end
            ACT_REM_FRONT: begin
                if (is_emp) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_rd = 1'b1;
                    raddr    = r_front;
                    n_front  = slot_at(r_front, AW'(1));
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_REM_BACK: begin
                if (is_emp) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_rd = 1'b1;
                    raddr    = slot_at(r_front, AW'(r_count - CW'(1)));
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_READ_AT: begin
                if (is_emp) begin
                    n_status = ST_EMPTY;
                end else if (bad_pos) begin
                    n_status = ST_RANGE;
                end else begin
                    n_use_rd = 1'b1;
                    raddr    = slot_at(r_front, i_in.item_value[AW-1:0]);
                end
            end
            ACT_PEEK_FRONT: begin
                if (is_emp) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_rd = 1'b1;
                    raddr    = r_front;
                end
            end
            ACT_PEEK_BACK: begin
                if (is_emp) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_rd = 1'b1;
                    raddr    = slot_at(r_front, AW'(r_count - CW'(1)));
                end
            end
            ACT_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        re = accept && n_use_rd;
    end

    // Writes land at the accept edge, so a following command's read sees them.
    deq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in.item_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Pointers and stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (accept) begin
                r_pend <= 1'b1;
            end else if (advance) begin
                r_pend <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payload; the read word itself is held inside the store.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_use_rd <= n_use_rd;
            r_status <= n_status;
            r_len    <= n_count;
        end
        if (advance) begin
            r_out_value  <= r_use_rd ? rdata : '0;
            r_out_status <= r_status;
            r_out_len    <= r_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.length_after = LEN_W'(r_out_len);
    assign o_out.is_empty     = (r_out_len == '0);

    // The count never passes the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // An accepted word always occupies the read stage next cycle.
    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pend)
        else $error("accepted word lost before read stage");

    // A new result only follows a word in the read stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pend))
        else $error("result word without a command");

    // A stalled read stage keeps its word, and its store data when it read one.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !out_free) |=> (r_pend && (!r_use_rd || $stable(rdata))))
        else $error("read stage changed while stalled");

endmodule

FILE: tb/tb_double_ended_queue_core.sv
// Self-checking bench for the double-ended queue core: directed table, then random traffic.
module tb_double_ended_queue_core;
    import deq_pkg::*;

    // One result word as the core should deliver it.
    typedef struct {
        logic signed [WORD_W-1:0] value;
        t_status                  status;
        logic [LEN_W-1:0]         length;
        logic                     empty;
    } t_outcome;

    // Per-command note: use the typed-in result instead of the mirror's one.
    typedef struct {
        bit       typed;
        t_outcome want;
    } t_note;

    // One row of the directed table; the argument advances by one per repeat.
    typedef struct {
        t_action                  act;
        logic signed [WORD_W-1:0] arg;
        int                       reps;
        bit                       typed;
        t_outcome                 want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_in_if  cmd_if ();
    deq_out_if res_if ();

    double_ended_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the queue: ring of words, front slot and word count.
    logic signed [WORD_W-1:0] mirror_ring [DEQ_DEPTH];
    int                       mirror_front = 0;
    int                       mirror_count = 0;

    t_outcome due_results [$];
    t_note    row_notes [$];
    t_row     plan [$];

    int  words_sent      = 0;
    int  results_checked = 0;
    int  err_count       = 0;
    bit  steady_run      = 1'b0;
    bit  want_holdoff    = 1'b0;

    // Apply one command to the mirror and return the result word it must produce.
    function automatic t_outcome apply_command(t_action act, logic signed [WORD_W-1:0] arg);
        t_outcome r;
        r.value  = '0;
        r.status = ST_OK;
        case (act)
            ACT_INS_FRONT: begin
                if (mirror_count >= DEQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_front = (mirror_front == 0) ? DEQ_DEPTH - 1 : mirror_front - 1;
                    mirror_ring[mirror_front] = arg;
                    mirror_count++;
                end
            end
            ACT_INS_BACK: begin
                if (mirror_count >= DEQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_ring[(mirror_front + mirror_count) % DEQ_DEPTH] = arg;
                    mirror_count++;
                end
            end
            ACT_REM_FRONT: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // The front keeps advancing even when the last word leaves.
                    r.value = mirror_ring[mirror_front];
                    mirror_front = (mirror_front + 1) % DEQ_DEPTH;
                    mirror_count--;
                end
            end
            ACT_REM_BACK: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = mirror_ring[(mirror_front + mirror_count - 1) % DEQ_DEPTH];
                    mirror_count--;
                end
            end
            ACT_READ_AT: begin
                // Empty wins over a bad position.
                if (mirror_count == 0)
                    r.status = ST_EMPTY;
                else if (arg < 0 || int'(arg) >= mirror_count)
                    r.status = ST_RANGE;
                else
                    r.value = mirror_ring[(mirror_front + int'(arg)) % DEQ_DEPTH];
            end
            ACT_PEEK_FRONT: begin
                if (mirror_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = mirror_ring[mirror_front];
            end
            ACT_PEEK_BACK: begin
                if (mirror_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = mirror_ring[(mirror_front + mirror_count - 1) % DEQ_DEPTH];
            end
            default: begin
                mirror_count = 0;
                mirror_front = 0;
            end
        endcase
        r.length = LEN_W'(mirror_count);
        r.empty  = (mirror_count == 0);
        return r;
    endfunction

    function automatic void add_row(t_action act, logic signed [WORD_W-1:0] arg, int reps,
                                    bit typed, logic signed [WORD_W-1:0] value = '0,
                                    t_status status = ST_OK, int length = 0,
                                    bit empty = 1'b0);
        t_row row;
        row.act          = act;
        row.arg          = arg;
        row.reps         = reps;
        row.typed        = typed;
        row.want.value   = value;
        row.want.status  = status;
        row.want.length  = LEN_W'(length);
        row.want.empty   = empty;
        plan.push_back(row);
    endfunction

    // Offer one command word, idling at random first, and hold it until taken.
    task automatic offer_word(t_action act, logic signed [WORD_W-1:0] arg, bit typed,
                              t_outcome want);
        t_note note;
        while (!steady_run && $urandom_range(0, 99) < 37) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        note.typed = typed;
        note.want  = want;
        row_notes.push_back(note);
        cmd_if.valid      <= 1'b1;
        cmd_if.action     <= act;
        cmd_if.item_value <= arg;
        do @(posedge i_clk); while (!cmd_if.ready);
        words_sent++;
    endtask

    // Accept side: compare each result word with the oldest expectation, then
    // log the command taken at this edge. Values are sampled before the edge updates.
    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        t_note    note;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                results_checked++;
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result word with nothing expected (value %0d)",
                             $time, res_if.result_value);
                end else begin
                    want = due_results.pop_front();
                    if (res_if.result_value !== want.value) begin
                        err_count++;
                        $display("%0t: result_value expected %0d got %0d",
                                 $time, want.value, res_if.result_value);
                    end
                    if (res_if.status !== want.status) begin
                        err_count++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, res_if.status);
                    end
                    if (res_if.length_after !== want.length) begin
                        err_count++;
                        $display("%0t: length_after expected %0d got %0d",
                                 $time, want.length, res_if.length_after);
                    end
                    if (res_if.is_empty !== want.empty) begin
                        err_count++;
                        $display("%0t: is_empty expected %0d got %0d",
                                 $time, want.empty, res_if.is_empty);
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                got = apply_command(t_action'(cmd_if.action), cmd_if.item_value);
                if (row_notes.size() != 0) begin
                    note = row_notes.pop_front();
                    if (note.typed)
                        got = note.want;
                end
                due_results.push_back(got);
            end
        end
    end

    // Result side: random back-pressure outside the steady run, plus one long hold-off on request so
    // the output register, the read stage and the input all back up.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_holdoff) begin
                want_holdoff = 1'b0;
                res_if.ready <= 1'b0;
                repeat (64) @(posedge i_clk);
            end else begin
                res_if.ready <= steady_run || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    initial begin
        #2000000;
        $display("double_ended_queue_core test failed");
        $finish;
    end

    initial begin
        int                       mode;
        int                       pick;
        t_action                  act;
        logic signed [WORD_W-1:0] arg;
        t_outcome                 none;

        none.value  = '0;
        none.status = ST_OK;
        none.length = '0;
        none.empty  = 1'b0;

        cmd_if.valid      <= 1'b0;
        cmd_if.action     <= ACT_INS_FRONT;
        cmd_if.item_value <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: every read-type action reports empty, read at included.
        add_row(ACT_PEEK_FRONT, 32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);
        add_row(ACT_PEEK_BACK,  32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);
        add_row(ACT_REM_FRONT,  32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);
        add_row(ACT_REM_BACK,   32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);
        add_row(ACT_READ_AT,    32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);
        // Extreme words at both ends, then positions in and out of range.
        add_row(ACT_INS_BACK,  32'sh7FFF_FFFF, 1, 1'b1, 32'sd0, ST_OK, 1);
        add_row(ACT_INS_FRONT, 32'sh8000_0000, 1, 1'b1, 32'sd0, ST_OK, 2);
        add_row(ACT_READ_AT, 32'sd0, 1, 1'b1, 32'sh8000_0000, ST_OK, 2);
        add_row(ACT_READ_AT, 32'sd1, 1, 1'b1, 32'sh7FFF_FFFF, ST_OK, 2);
        add_row(ACT_READ_AT, 32'sd2, 1, 1'b1, 32'sd0, ST_RANGE, 2);
        add_row(ACT_READ_AT, -32'sd1, 1, 1'b1, 32'sd0, ST_RANGE, 2);
        add_row(ACT_READ_AT, 32'sh8000_0000, 1, 1'b1, 32'sd0, ST_RANGE, 2);
        add_row(ACT_PEEK_FRONT, 32'sd0, 1, 1'b1, 32'sh8000_0000, ST_OK, 2);
        add_row(ACT_PEEK_BACK,  32'sd0, 1, 1'b1, 32'sh7FFF_FFFF, ST_OK, 2);
        add_row(ACT_REM_BACK,   32'sd0, 1, 1'b1, 32'sh7FFF_FFFF, ST_OK, 1);
        // Removing the last word empties the queue.
        add_row(ACT_REM_FRONT,  32'sd0, 1, 1'b1, 32'sh8000_0000, ST_OK, 0, 1'b1);
        // Fill from both ends to full, then inserts are refused.
        add_row(ACT_INS_FRONT, 32'sh0000_1000, 8, 1'b0);
        add_row(ACT_INS_BACK,  32'sh5A5A_0000, 8, 1'b0);
        add_row(ACT_INS_FRONT, 32'sh0000_1234, 1, 1'b1, 32'sd0, ST_FULL, 16);
        add_row(ACT_INS_BACK,  32'sh0000_1234, 1, 1'b1, 32'sd0, ST_FULL, 16);
        add_row(ACT_READ_AT, 32'sd15, 1, 1'b0);
        add_row(ACT_READ_AT, 32'sd16, 1, 1'b1, 32'sd0, ST_RANGE, 16);
        add_row(ACT_REM_FRONT, 32'sd0, 3, 1'b0);
        add_row(ACT_CLEAR, 32'sd0, 1, 1'b1, 32'sd0, ST_OK, 0, 1'b1);
        add_row(ACT_REM_BACK, 32'sd0, 1, 1'b1, 32'sd0, ST_EMPTY, 0, 1'b1);

        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
                offer_word(plan[i].act, plan[i].arg + k, plan[i].typed, plan[i].want);

        // Random traffic: switch between fill-heavy, drain-heavy and balanced
        // mixes so the ring wraps and both the full and empty edges get hit often.
        mode = 0;
        for (int n = 0; n < 750; n++) begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            steady_run = (n >= 300 && n < 420);
            if (n == 150)
                want_holdoff = 1'b1;
            if (n == 550) begin
                // Pause until the core has drained every pending result word.
                cmd_if.valid <= 1'b0;
                while (results_checked != words_sent) @(posedge i_clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < (mode == 0 ? 60 : mode == 1 ? 20 : 35))
                act = ($urandom_range(0, 1) == 0) ? ACT_INS_FRONT : ACT_INS_BACK;
            else if (pick < (mode == 0 ? 75 : mode == 1 ? 70 : 65))
                act = ($urandom_range(0, 1) == 0) ? ACT_REM_FRONT : ACT_REM_BACK;
            else if (pick < (mode == 0 ? 87 : mode == 1 ? 82 : 77))
                act = ACT_READ_AT;
            else if (pick < 98)
                act = ($urandom_range(0, 1) == 0) ? ACT_PEEK_FRONT : ACT_PEEK_BACK;
            else
                act = ACT_CLEAR;

            pick = $urandom_range(0, 99);
            if (act == ACT_READ_AT) begin
                if (pick < 70)
                    arg = $urandom_range(0, 17);
                else if (pick < 85)
                    arg = $urandom;
                else
                    arg = -$signed({1'b0, 31'($urandom_range(1, 4))});
            end else begin
                if (pick < 80)
                    arg = $urandom;
                else if (pick < 90)
                    arg = ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                else
                    arg = $urandom_range(0, 255);
            end
            offer_word(act, arg, 1'b0, none);
        end
        steady_run = 1'b0;
        cmd_if.valid <= 1'b0;

        // Drain, then idle so that a stray result word would still show.
        while (results_checked != words_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_count == 0)
            $display("double_ended_queue_core test passed");
        else
            $display("double_ended_queue_core test failed");
        $finish;
    end

endmodule
